@@ rtl/core/mwwf_pkg.sv @@
// ----------------------------------------------------------------------------
// mwwf_pkg - shared types and constants for the Modbus write whitelist filter
// Rule entry layout, field widths, function codes and verdict/reason codes.
// ----------------------------------------------------------------------------
package mwwf_pkg;

    localparam int RULE_DEPTH = 128;
    localparam int MAX_FRAME  = 512;

    // index into the rule table, and a count that can hold RULE_DEPTH itself
    localparam int IDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
    localparam int CNT_W = $clog2(RULE_DEPTH + 1);

    localparam int IN_LEN_W  = 10;
    localparam int LEN_W     = ($clog2(MAX_FRAME + 1) > IN_LEN_W) ?
                               $clog2(MAX_FRAME + 1) : IN_LEN_W;
    localparam int FC_W      = 8;
    localparam int ADDR_W    = 16;
    localparam int VAL_W     = 16;
    localparam int LIM_W     = 18;
    localparam int MATCH_W   = 7;
    localparam int VERDICT_W = 2;
    localparam int REASON_W  = 3;
    localparam int EXC_W     = 2;

    localparam int MBAP_LEN  = 7;
    localparam int MIN_FRAME = 8;
    localparam int MIN_PDU   = 5;

    localparam logic [FC_W-1:0]  FC_WR_COIL       = 8'h05;
    localparam logic [FC_W-1:0]  FC_WR_REG        = 8'h06;
    localparam logic [FC_W-1:0]  FC_WR_COILS      = 8'h0F;
    localparam logic [FC_W-1:0]  FC_WR_REGS       = 8'h10;
    localparam logic [FC_W-1:0]  EXC_FLAG         = 8'h80;
    localparam logic [EXC_W-1:0] EXC_ILLEGAL_ADDR = 2'd2;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_FORWARD = 2'd0,
        VERDICT_BLOCK   = 2'd1,
        VERDICT_STORED  = 2'd2,
        VERDICT_DROPPED = 2'd3
    } verdict_t;

    typedef enum logic [REASON_W-1:0] {
        REASON_NONE      = 3'd0,
        REASON_SHORT     = 3'd1,
        REASON_ALLOWED   = 3'd2,
        REASON_PDU_SHORT = 3'd3,
        REASON_NO_RULE   = 3'd4,
        REASON_RANGE     = 3'd5
    } reason_t;

    typedef struct packed {
        logic        [FC_W-1:0]   fc;
        logic        [ADDR_W-1:0] addr;
        logic signed [LIM_W-1:0]  min;
        logic signed [LIM_W-1:0]  max;
    } rule_t;

    function automatic logic is_write_fc(input logic [FC_W-1:0] fc);
        return (fc == FC_WR_COIL) || (fc == FC_WR_REG) ||
               (fc == FC_WR_COILS) || (fc == FC_WR_REGS);
    endfunction

    // table index as reported: wraps to MATCH_W bits, or zero-extends
    function automatic logic [MATCH_W-1:0] match_index(input logic [IDX_W-1:0] idx);
        logic [MATCH_W+IDX_W-1:0] wide;
        wide = {{MATCH_W{1'b0}}, idx};
        return wide[MATCH_W-1:0];
    endfunction

endpackage

@@ rtl/core/mwwf_rule_table.sv @@
// ----------------------------------------------------------------------------
// mwwf_rule_table - whitelist rule storage
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module mwwf_rule_table (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [mwwf_pkg::IDX_W-1:0] wr_addr,
    input  mwwf_pkg::rule_t          wr_data,
    input  logic                     rd_en,
    input  logic [mwwf_pkg::IDX_W-1:0] rd_addr,
    output mwwf_pkg::rule_t          rd_data
);
    import mwwf_pkg::*;

    rule_t mem [RULE_DEPTH];
    rule_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/modbus_write_whitelist_filter_core.sv @@
// ----------------------------------------------------------------------------
// modbus_write_whitelist_filter_core - Modbus TCP write firewall
// Stores whitelist rules and judges decoded frames against them, one word
// in and one result word out per item.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | word fields
//  ---------+-------------------------+------------------------------------------
//  input    | in_valid / in_stall     | mode .. rule_max (7 fields)
//  output   | out_valid / out_stall   | verdict .. exception_code (6 fields)
//
//  Order: a load, a short frame, a non-write and a short PDU go from acceptance
//  straight to the emit state. A write frame scans the stored rules in table order,
//  reading one entry while comparing the one before, and stops at the first match;
//  a single-register write then checks its value against min, then against max.
//  The input is free again once the result is in the output register. Reset clears
//  the rule count and all control and output registers, but not the rule memory.
//
module modbus_write_whitelist_filter_core (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [mwwf_pkg::IN_LEN_W-1:0]   frame_length,
    input  logic [mwwf_pkg::FC_W-1:0]       func_code,
    input  logic [mwwf_pkg::ADDR_W-1:0]     register_address,
    input  logic [mwwf_pkg::VAL_W-1:0]      write_value,
    input  logic signed [mwwf_pkg::LIM_W-1:0] rule_min,
    input  logic signed [mwwf_pkg::LIM_W-1:0] rule_max,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mwwf_pkg::VERDICT_W-1:0]  verdict,
    output logic [mwwf_pkg::REASON_W-1:0]   reason,
    output logic                            rule_hit,
    output logic [mwwf_pkg::MATCH_W-1:0]    matched_rule,
    output logic [mwwf_pkg::FC_W-1:0]       exception_function,
    output logic [mwwf_pkg::EXC_W-1:0]      exception_code
);
    import mwwf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MIN,
        S_MAX,
        S_EMIT
    } state_t;

    typedef struct packed {
        verdict_t           verdict;
        reason_t            reason;
        logic               hit;
        logic [MATCH_W-1:0] idx;
        logic [FC_W-1:0]    exf;
        logic [EXC_W-1:0]   exc;
    } res_t;

    // blocked words carry the exception reply, everything else zeros
    function automatic res_t make_res(input verdict_t v, input reason_t r,
                                      input logic hit, input logic [IDX_W-1:0] idx,
                                      input logic [FC_W-1:0] fc);
        res_t res;
        res.verdict = v;
        res.reason  = r;
        res.hit     = hit;
        res.idx     = hit ? match_index(idx) : '0;
        res.exf     = (v == VERDICT_BLOCK) ? (fc | EXC_FLAG) : '0;
        res.exc     = (v == VERDICT_BLOCK) ? EXC_ILLEGAL_ADDR : '0;
        return res;
    endfunction

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic [FC_W-1:0]    fc_reg, fc_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [VAL_W-1:0]   value_reg, value_next;
    res_t               res_reg, res_next;
    res_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    // rule table port
    logic               wr_en;
    rule_t              wr_data;
    logic               rd_en;
    rule_t              rd_data;

    // shared signed range comparator
    logic signed [LIM_W-1:0] cmp_a, cmp_b;
    logic                    cmp_lt;
    logic signed [LIM_W-1:0] value_s;

    logic [LEN_W-1:0]   len_c;
    logic               entry_match;

    mwwf_rule_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign wr_data = '{fc: func_code, addr: register_address,
                       min: rule_min, max: rule_max};

    // receive buffer limit; never alters a decision at legal sizes
    always_comb
    begin
        len_c = LEN_W'(frame_length);
        if (len_c > LEN_W'(MAX_FRAME))
        begin
            len_c = LEN_W'(MAX_FRAME);
        end
    end

    assign value_s     = signed'({{(LIM_W-VAL_W){1'b0}}, value_reg});
    assign cmp_lt      = cmp_a < cmp_b;
    assign entry_match = cmp_valid_reg && (rd_data.fc == fc_reg) &&
                         (rd_data.addr == addr_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        hit_idx_next   = hit_idx_reg;
        fc_next        = fc_reg;
        addr_next      = addr_reg;
        value_next     = value_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        cmp_a          = value_s;
        cmp_b          = rd_data.min;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    fc_next    = func_code;
                    addr_next  = register_address;
                    value_next = write_value;
                    state_next = S_EMIT;
                    if (mode)
                    begin
                        if (count_reg < CNT_W'(RULE_DEPTH))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + 1'b1;
                            res_next   = make_res(VERDICT_STORED, REASON_NONE, 1'b0,
                                                  '0, func_code);
                        end
                        else
                        begin
                            res_next = make_res(VERDICT_DROPPED, REASON_NONE, 1'b0,
                                                '0, func_code);
                        end
                    end
                    else if (len_c < LEN_W'(MIN_FRAME))
                    begin
                        res_next = make_res(VERDICT_FORWARD, REASON_SHORT, 1'b0,
                                            '0, func_code);
                    end
                    else if (!is_write_fc(func_code))
                    begin
                        res_next = make_res(VERDICT_FORWARD, REASON_NONE, 1'b0,
                                            '0, func_code);
                    end
                    else if (len_c < LEN_W'(MBAP_LEN + MIN_PDU))
                    begin
                        res_next = make_res(VERDICT_BLOCK, REASON_PDU_SHORT, 1'b0,
                                            '0, func_code);
                    end
                    else
                    begin
                        scan_idx_next  = '0;
                        cmp_valid_next = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // read of entry n overlaps compare of entry n-1
                if (entry_match)
                begin
                    hit_idx_next = cmp_idx_reg;
                    if (fc_reg == FC_WR_REG)
                    begin
                        state_next = S_MIN;
                    end
                    else
                    begin
                        res_next   = make_res(VERDICT_FORWARD, REASON_ALLOWED, 1'b1,
                                              cmp_idx_reg, fc_reg);
                        state_next = S_EMIT;
                    end
                end
                else if (scan_idx_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end
                else if (cmp_valid_reg)
                begin
                    cmp_valid_next = 1'b0;
                end
                else
                begin
                    res_next   = make_res(VERDICT_BLOCK, REASON_NO_RULE, 1'b0,
                                          '0, fc_reg);
                    state_next = S_EMIT;
                end
            end

            S_MIN:
            begin
                cmp_a = value_s;
                cmp_b = rd_data.min;
                if (cmp_lt)
                begin
                    res_next   = make_res(VERDICT_BLOCK, REASON_RANGE, 1'b1,
                                          hit_idx_reg, fc_reg);
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_MAX;
                end
            end

            S_MAX:
            begin
                cmp_a = rd_data.max;
                cmp_b = value_s;
                if (cmp_lt)
                begin
                    res_next = make_res(VERDICT_BLOCK, REASON_RANGE, 1'b1,
                                        hit_idx_reg, fc_reg);
                end
                else
                begin
                    res_next = make_res(VERDICT_FORWARD, REASON_ALLOWED, 1'b1,
                                        hit_idx_reg, fc_reg);
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            hit_idx_reg   <= '0;
            fc_reg        <= '0;
            addr_reg      <= '0;
            value_reg     <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_idx_reg   <= hit_idx_next;
            fc_reg        <= fc_next;
            addr_reg      <= addr_next;
            value_reg     <= value_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall           = (state_reg != S_IDLE);
    assign out_valid          = out_valid_reg;
    assign verdict            = out_reg.verdict;
    assign reason             = out_reg.reason;
    assign rule_hit           = out_reg.hit;
    assign matched_rule       = out_reg.idx;
    assign exception_function = out_reg.exf;
    assign exception_code     = out_reg.exc;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RULE_DEPTH))
        else $error("rule count beyond table depth");

    a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode && (count_reg < CNT_W'(RULE_DEPTH)))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("stored rule did not advance the count");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (state_reg == S_SCAN) && (scan_idx_reg < count_reg))
        else $error("table read beyond stored rules");

    a_block_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (verdict == VERDICT_BLOCK))
        |-> exception_function[FC_W-1] && (exception_code == EXC_ILLEGAL_ADDR))
        else $error("blocked word without exception reply");

    a_hit_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rule_hit)
        |-> (reason == REASON_ALLOWED) || (reason == REASON_RANGE))
        else $error("rule hit with unrelated reason");

endmodule

@@ test/modbus_write_whitelist_filter_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_write_whitelist_filter_core_tb - self-checking bench for the filter
// Loads whitelist rules and pushes decoded frames through the core with random
// gaps and stalls on both channels. Every result word is checked, field by
// field, against a scoreboard fed by an independent model of the filter.
// ----------------------------------------------------------------------------
module modbus_write_whitelist_filter_core_tb;

    import mwwf_pkg::*;

    localparam logic MODE_INSPECT = 1'b0;
    localparam logic MODE_LOAD    = 1'b1;

    // a read function code, used as a typical non-write frame
    localparam logic [FC_W-1:0] FC_RD_HOLDING = 8'h03;

    localparam int RANDOM_WORDS = 500;
    localparam int ADDR_POOL_SZ = 24;
    localparam int HOLD_AT      = 150;     // results seen before the long hold
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 300;     // beyond a full table scan plus a stall

    // one input word, plus a flag telling the driver to wait for a drained core
    typedef struct {
        logic                     mode;
        logic [IN_LEN_W-1:0]      len;
        logic [FC_W-1:0]          fc;
        logic [ADDR_W-1:0]        addr;
        logic [VAL_W-1:0]         value;
        logic signed [LIM_W-1:0]  lo;
        logic signed [LIM_W-1:0]  hi;
        bit                       drain_first;
    } frame_word_t;

    typedef struct {
        verdict_t             verdict;
        reason_t              reason;
        logic                 hit;
        logic [MATCH_W-1:0]   idx;
        logic [FC_W-1:0]      exf;
        logic [EXC_W-1:0]     exc;
    } filter_verdict_t;

    typedef struct {
        logic [FC_W-1:0]   fc;
        logic [ADDR_W-1:0] addr;
        int                lo;
        int                hi;
    } allow_rule_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     mode = 1'b0;
    logic [IN_LEN_W-1:0]      frame_length = '0;
    logic [FC_W-1:0]          func_code = '0;
    logic [ADDR_W-1:0]        register_address = '0;
    logic [VAL_W-1:0]         write_value = '0;
    logic signed [LIM_W-1:0]  rule_min = '0;
    logic signed [LIM_W-1:0]  rule_max = '0;

    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [VERDICT_W-1:0]     verdict;
    logic [REASON_W-1:0]      reason;
    logic                     rule_hit;
    logic [MATCH_W-1:0]       matched_rule;
    logic [FC_W-1:0]          exception_function;
    logic [EXC_W-1:0]         exception_code;

    // stimulus and scoreboard
    frame_word_t      frame_words[$];
    filter_verdict_t  pending_verdicts[$];
    frame_word_t      loaded_rules[$];     // generator's view of stored rules
    int               loads_queued = 0;

    // model state
    allow_rule_t      allow_list[RULE_DEPTH];
    int               allow_count = 0;

    int               mismatches = 0;
    int               verdicts_seen = 0;

    frame_word_t      live_word;
    bit               send_took;
    int               send_gap = 0;
    bit               send_calm = 0;
    int               recv_gap = 0;
    bit               recv_calm = 0;
    logic             hold_on = 1'b0;
    int               hold_left = 0;
    bit               hold_used = 0;
    int               addr_pool[ADDR_POOL_SZ];

    modbus_write_whitelist_filter_core dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .mode               (mode),
        .frame_length       (frame_length),
        .func_code          (func_code),
        .register_address   (register_address),
        .write_value        (write_value),
        .rule_min           (rule_min),
        .rule_max           (rule_max),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .verdict            (verdict),
        .reason             (reason),
        .rule_hit           (rule_hit),
        .matched_rule       (matched_rule),
        .exception_function (exception_function),
        .exception_code     (exception_code)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Filter model: updates the rule table on a load, judges a frame otherwise
    // ------------------------------------------------------------------------
    function automatic filter_verdict_t judge_word(input frame_word_t w);
        filter_verdict_t r;
        int len;
        int i;
        bit is_write;
        r.verdict = VERDICT_FORWARD;
        r.reason  = REASON_NONE;
        r.hit     = 1'b0;
        r.idx     = '0;
        r.exf     = '0;
        r.exc     = '0;
        if (w.mode == MODE_LOAD)
        begin
            if (allow_count < RULE_DEPTH)
            begin
                allow_list[allow_count].fc   = w.fc;
                allow_list[allow_count].addr = w.addr;
                allow_list[allow_count].lo   = w.lo;
                allow_list[allow_count].hi   = w.hi;
                allow_count++;
                r.verdict = VERDICT_STORED;
            end
            else
                r.verdict = VERDICT_DROPPED;
            return r;
        end
        // receive buffer clips the length; no decision depends on it
        len = w.len;
        if (len > MAX_FRAME)
            len = MAX_FRAME;
        if (len < MIN_FRAME)
        begin
            r.reason = REASON_SHORT;
            return r;
        end
        case (w.fc)
            FC_WR_COIL, FC_WR_REG, FC_WR_COILS, FC_WR_REGS: is_write = 1'b1;
            default:                                        is_write = 1'b0;
        endcase
        if (!is_write)
            return r;
        r.verdict = VERDICT_BLOCK;
        r.exf     = w.fc | EXC_FLAG;
        r.exc     = EXC_ILLEGAL_ADDR;
        if (len - MBAP_LEN < MIN_PDU)
        begin
            r.reason = REASON_PDU_SHORT;
            return r;
        end
        // first rule in table order wins
        for (i = 0; i < allow_count; i++)
            if (allow_list[i].fc == w.fc && allow_list[i].addr == w.addr)
                break;
        if (i >= allow_count)
        begin
            r.reason = REASON_NO_RULE;
            return r;
        end
        r.hit = 1'b1;
        r.idx = MATCH_W'(i);
        if (w.fc == FC_WR_REG && (int'(w.value) < allow_list[i].lo ||
                                  int'(w.value) > allow_list[i].hi))
        begin
            r.reason = REASON_RANGE;
            return r;
        end
        r.verdict = VERDICT_FORWARD;
        r.reason  = REASON_ALLOWED;
        r.exf     = '0;
        r.exc     = '0;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders; fields the core ignores carry random junk
    // ------------------------------------------------------------------------
    function automatic frame_word_t mk_frame(input int len, input logic [FC_W-1:0] fc,
                                             input int addr, input int value);
        frame_word_t w;
        w.mode        = MODE_INSPECT;
        w.len         = IN_LEN_W'(len);
        w.fc          = fc;
        w.addr        = ADDR_W'(addr);
        w.value       = VAL_W'(value);
        w.lo          = LIM_W'($urandom);
        w.hi          = LIM_W'($urandom);
        w.drain_first = 1'b0;
        return w;
    endfunction

    function automatic frame_word_t mk_rule(input logic [FC_W-1:0] fc, input int addr,
                                            input int lo, input int hi);
        frame_word_t w;
        w.mode        = MODE_LOAD;
        w.len         = IN_LEN_W'($urandom);
        w.fc          = fc;
        w.addr        = ADDR_W'(addr);
        w.value       = VAL_W'($urandom);
        w.lo          = LIM_W'(lo);
        w.hi          = LIM_W'(hi);
        w.drain_first = 1'b0;
        return w;
    endfunction

    function automatic logic [FC_W-1:0] pick_write_fc();
        case ($urandom_range(0, 3))
            0:       return FC_WR_COIL;
            1:       return FC_WR_REG;
            2:       return FC_WR_COILS;
            default: return FC_WR_REGS;
        endcase
    endfunction

    // idle cycles before the next word; stretches of zero idling come and go
    function automatic int pick_idle(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        if (calm)
            return 0;
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
    endfunction

    task automatic queue_word(input frame_word_t w);
        frame_words.push_back(w);
        if (w.mode == MODE_LOAD)
        begin
            if (loads_queued < RULE_DEPTH)
                loaded_rules.push_back(w);
            loads_queued++;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("%0t ns: mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int n,
                               input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d %s got %0h want %0h", n, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued words, predicts each one as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid         <= 1'b0;
            mode             <= 1'b0;
            frame_length     <= '0;
            func_code        <= '0;
            register_address <= '0;
            write_value      <= '0;
            rule_min         <= '0;
            rule_max         <= '0;
            send_gap = 0;
        end
        else
        begin
            send_took = in_valid && !in_stall;
            if (send_took)
            begin
                pending_verdicts.push_back(judge_word(live_word));
                send_gap = pick_idle(send_calm);
            end
            // in_valid gets one assignment per edge; a word held high stays high
            if (!in_valid || send_took)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (frame_words.size() == 0)
                    in_valid <= 1'b0;
                else if (frame_words[0].drain_first && pending_verdicts.size() != 0)
                    in_valid <= 1'b0;
                else
                begin
                    live_word = frame_words.pop_front();
                    mode             <= live_word.mode;
                    frame_length     <= live_word.len;
                    func_code        <= live_word.fc;
                    register_address <= live_word.addr;
                    write_value      <= live_word.value;
                    rule_min         <= live_word.lo;
                    rule_max         <= live_word.hi;
                    in_valid         <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold, once: the core fills up and stalls its input
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_on <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (!hold_used && verdicts_seen >= HOLD_AT)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            hold_on <= (hold_left > 0);
            if (hold_left > 0)
                hold_left--;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes result words and checks them against the scoreboard
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        filter_verdict_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                verdicts_seen++;
                if (pending_verdicts.size() == 0)
                    flag_mismatch($sformatf("result %0d with nothing expected",
                                            verdicts_seen));
                else
                begin
                    want = pending_verdicts.pop_front();
                    check_field("verdict", verdicts_seen, 8'(verdict), 8'(want.verdict));
                    check_field("reason", verdicts_seen, 8'(reason), 8'(want.reason));
                    check_field("rule_hit", verdicts_seen, 8'(rule_hit), 8'(want.hit));
                    check_field("matched_rule", verdicts_seen, 8'(matched_rule),
                                8'(want.idx));
                    check_field("exception_function", verdicts_seen,
                                exception_function, want.exf);
                    check_field("exception_code", verdicts_seen, 8'(exception_code),
                                8'(want.exc));
                end
                recv_gap = pick_idle(recv_calm);
            end
            if (hold_on)
                out_stall <= 1'b1;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin : run_ctrl
        frame_word_t w;
        frame_word_t r;
        int n;
        int k;
        int a;
        int b;
        int roll;
        int lo;
        int hi;
        bit is_load;

        rst_n = 1'b0;

        addr_pool[0] = 0;
        addr_pool[1] = 16'hFFFF;
        for (n = 2; n < ADDR_POOL_SZ; n++)
            addr_pool[n] = $urandom_range(0, 16'hFFFF);

        // empty table, length edges, short PDU, non-write codes
        queue_word(mk_frame(12, FC_WR_REG, 0, 0));
        queue_word(mk_frame(0, FC_WR_REG, 0, 0));
        queue_word(mk_frame(7, FC_WR_COIL, 16'h1234, 0));
        queue_word(mk_frame(8, FC_WR_REGS, 16'h0020, 0));
        queue_word(mk_frame(11, FC_WR_COIL, 16'h1234, 0));
        queue_word(mk_frame(12, FC_RD_HOLDING, 16'h1234, 0));
        queue_word(mk_frame(1023, 8'hFF, 16'hFFFF, 16'hFFFF));
        // rules: full range, narrow range, shadowed duplicate, empty range
        queue_word(mk_rule(FC_WR_REG, 16'h0000, -1, 65536));
        queue_word(mk_rule(FC_WR_REG, 16'hFFFF, 100, 200));
        queue_word(mk_rule(FC_WR_COIL, 16'h1234, 0, 0));
        queue_word(mk_rule(FC_WR_COILS, 16'h0010, 0, 0));
        queue_word(mk_rule(FC_WR_REGS, 16'h0020, 0, 0));
        queue_word(mk_rule(FC_WR_REG, 16'hFFFF, 0, 65535));
        queue_word(mk_rule(FC_WR_REG, 16'h0040, 500, 100));
        // hits, range edges either side, oversized frame, function mismatch
        queue_word(mk_frame(12, FC_WR_REG, 16'h0000, 0));
        queue_word(mk_frame(12, FC_WR_REG, 16'h0000, 16'hFFFF));
        queue_word(mk_frame(13, FC_WR_REG, 16'hFFFF, 99));
        queue_word(mk_frame(12, FC_WR_REG, 16'hFFFF, 100));
        queue_word(mk_frame(12, FC_WR_REG, 16'hFFFF, 200));
        queue_word(mk_frame(12, FC_WR_REG, 16'hFFFF, 201));
        queue_word(mk_frame(512, FC_WR_COIL, 16'h1234, 16'hFF00));
        queue_word(mk_frame(1023, FC_WR_COILS, 16'h0010, 0));
        queue_word(mk_frame(260, FC_WR_REGS, 16'h0020, 0));
        queue_word(mk_frame(12, FC_WR_REGS, 16'h1234, 0));
        queue_word(mk_frame(12, FC_WR_REG, 16'h0040, 300));

        // random part: fill the table early, then mostly writes aimed at rules
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            roll = $urandom_range(0, 99);
            is_load = (loads_queued < RULE_DEPTH) ? (roll < 45) : (roll < 5);
            if (is_load)
            begin
                a = ($urandom_range(0, 9) != 0) ? pick_write_fc() : $urandom_range(0, 255);
                b = ($urandom_range(0, 9) < 7) ? addr_pool[$urandom_range(0, ADDR_POOL_SZ-1)]
                                               : $urandom_range(0, 16'hFFFF);
                case ($urandom_range(0, 3))
                    0:
                    begin
                        lo = -1;
                        hi = 65536;
                    end
                    1:
                    begin
                        lo = $urandom_range(0, 16'hFFFF);
                        hi = $urandom_range(0, 16'hFFFF);
                        if (lo > hi)
                        begin
                            k = lo;
                            lo = hi;
                            hi = k;
                        end
                    end
                    2:
                    begin
                        lo = $urandom_range(0, 16'hFFFF);
                        hi = lo + $urandom_range(0, 40);
                    end
                    default:
                    begin
                        // raw 18-bit limits, sign bit included
                        lo = $urandom_range(0, 18'h3FFFF);
                        hi = $urandom_range(0, 18'h3FFFF);
                    end
                endcase
                w = mk_rule(FC_W'(a), b, lo, hi);
            end
            else if (roll < 85)
            begin
                case ($urandom_range(0, 9))
                    0:       a = $urandom_range(8, 11);
                    1:       a = $urandom_range(513, 1023);
                    default: a = $urandom_range(12, 260);
                endcase
                if (loaded_rules.size() != 0 && $urandom_range(0, 9) < 8)
                begin
                    r = loaded_rules[$urandom_range(0, loaded_rules.size() - 1)];
                    if ($urandom_range(0, 2) == 0)
                        b = $urandom_range(0, 16'hFFFF);
                    else
                    begin
                        // either side of a rule bound
                        b = int'($urandom_range(0, 2)) - 1;
                        if ($urandom_range(0, 1))
                            b += r.lo;
                        else
                            b += r.hi;
                        if (b < 0)
                            b = 0;
                        if (b > 16'hFFFF)
                            b = 16'hFFFF;
                    end
                    w = mk_frame(a, r.fc, r.addr, b);
                end
                else
                    w = mk_frame(a, pick_write_fc(),
                                 addr_pool[$urandom_range(0, ADDR_POOL_SZ-1)],
                                 $urandom_range(0, 16'hFFFF));
            end
            else
                w = mk_frame($urandom_range(0, 1023), FC_W'($urandom_range(0, 255)),
                             $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
            // sender waits for a drained core here and there
            if (n == 0 || n == 300)
                w.drain_first = 1'b1;
            queue_word(w);
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (frame_words.size() != 0 || in_valid || pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_verdicts.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));

        if (mismatches == 0)
            $display("modbus_write_whitelist_filter_core_tb: done, clean");
        else
            $display("modbus_write_whitelist_filter_core_tb: done, errors");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("modbus_write_whitelist_filter_core_tb: done, errors");
        $finish;
    end

endmodule
